// File: hdl/wdp_pkg.sv
// Shared types, codes and sizes for the windowed dot-plot cell unit.
package wdp_pkg;

    localparam int unsigned MAX_LEN_DEF    = 4096;
    localparam int unsigned MAX_WINDOW_DEF = 31;

    localparam int unsigned FUNC_W = 2;
    localparam int unsigned IDX_W  = 12;
    localparam int unsigned SYM_W  = 8;
    localparam int unsigned LEN_W  = 13;
    localparam int unsigned WIN_W  = 5;
    localparam int unsigned CNT_W  = 5;
    // sequence position; holds any loaded length
    localparam int unsigned POS_W  = 13;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 13;

    localparam logic [FUNC_W-1:0] FUNC_WR_A  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WR_B  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_LENGTH_A  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH_B  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ALLOWANCE = 2'd3;

    localparam logic [WIN_W-1:0] WINDOW_RST    = 5'd9;
    localparam logic [WIN_W-1:0] ALLOWANCE_RST = 5'd2;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [IDX_W-1:0]  load_index;
        logic [SYM_W-1:0]  symbol;
        logic [IDX_W-1:0]  col;
        logic [IDX_W-1:0]  row;
    } in_item_t;

    typedef struct packed {
        logic             dot;
        logic [CNT_W-1:0] match_count;
        logic             out_of_range;
    } out_item_t;

    // one symbol store port pair: write from loads, read from the sequencer
    typedef struct packed {
        logic             we;
        logic [POS_W-1:0] waddr;
        logic [SYM_W-1:0] wdata;
        logic             re;
        logic [POS_W-1:0] raddr;
    } mem_req_t;

endpackage

// File: hdl/windowed_dot_plot_cell_unit.sv
// Top level of the windowed dot-plot cell unit: sequencer plus the two symbol stores.
//
//  channel  | direction | handshake            | payload
//  s_       | in        | s_valid / s_ready    | s_data  (func, load_index, symbol, col, row)
//  m_       | out       | m_valid / m_ready    | m_data  (dot, match_count, out_of_range)
//  cfg_     | in        | cfg_we (no wait)     | cfg_index, cfg_wdata
//
// Load beat: written into the store at acceptance.
// Query beat: compares up to the window of pairs, one pair per cycle, set by the single read
// port of each store. An out-of-range query skips the compare and goes straight to FIN.
// A finished result sits in the output register; the next beat is taken while it waits.
// The sequencer stalls only when a new result is ready and the output register is full with m_ready low.
// Reset is synchronous on aresetn; store contents are undefined until loaded.
module windowed_dot_plot_cell_unit #(
    parameter int unsigned MAX_LEN    = wdp_pkg::MAX_LEN_DEF,
    parameter int unsigned MAX_WINDOW = wdp_pkg::MAX_WINDOW_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  wdp_pkg::in_item_t              s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output wdp_pkg::out_item_t             m_data,
    input  logic                           cfg_we,
    input  logic [wdp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wdp_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    wdp_pkg::mem_req_t         req_a, req_b;
    logic [wdp_pkg::SYM_W-1:0] rd_a, rd_b;

    wdp_ctrl #(
        .MAX_LEN    (MAX_LEN),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req_a     (req_a),
        .req_b     (req_b),
        .rd_a      (rd_a),
        .rd_b      (rd_b)
    );

    wdp_ram #(
        .DEPTH (MAX_LEN)
    ) u_store_a (
        .aclk    (aclk),
        .req     (req_a),
        .rd_data (rd_a)
    );

    wdp_ram #(
        .DEPTH (MAX_LEN)
    ) u_store_b (
        .aclk    (aclk),
        .req     (req_b),
        .rd_data (rd_b)
    );

endmodule

// File: hdl/wdp_ram.sv
// Symbol store: one write port, one registered read port.
module wdp_ram #(
    parameter int unsigned DEPTH = wdp_pkg::MAX_LEN_DEF
) (
    input  logic                     aclk,
    input  wdp_pkg::mem_req_t        req,
    output logic [wdp_pkg::SYM_W-1:0] rd_data
);

    localparam int unsigned AddrW = $clog2(DEPTH);

    logic [wdp_pkg::SYM_W-1:0] mem [DEPTH];
    logic [wdp_pkg::SYM_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[AddrW'(req.waddr)] <= req.wdata;
        end
        if (req.re) begin
            rd_data_reg <= mem[AddrW'(req.raddr)];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/wdp_ctrl.sv
// Config registers, load decode and the query sequencer with its compare/count unit.
module wdp_ctrl #(
    parameter int unsigned MAX_LEN    = wdp_pkg::MAX_LEN_DEF,
    parameter int unsigned MAX_WINDOW = wdp_pkg::MAX_WINDOW_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  wdp_pkg::in_item_t                s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output wdp_pkg::out_item_t               m_data,
    input  logic                             cfg_we,
    input  logic [wdp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [wdp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output wdp_pkg::mem_req_t                req_a,
    output wdp_pkg::mem_req_t                req_b,
    input  logic [wdp_pkg::SYM_W-1:0]        rd_a,
    input  logic [wdp_pkg::SYM_W-1:0]        rd_b
);

    localparam int unsigned LenW = wdp_pkg::LEN_W;
    localparam int unsigned WinW = wdp_pkg::WIN_W;
    localparam int unsigned CntW = wdp_pkg::CNT_W;
    localparam int unsigned PosW = wdp_pkg::POS_W;

    localparam int unsigned LenCap = (MAX_LEN > 8191) ? 8191 : MAX_LEN;
    localparam int unsigned IdxCap = (MAX_LEN > 4096) ? 4096 : MAX_LEN;
    localparam int unsigned WinCap = (MAX_WINDOW > 31) ? 31 : MAX_WINDOW;
    localparam logic [LenW-1:0] LenMax = LenW'(LenCap);
    localparam logic [LenW-1:0] IdxLim = LenW'(IdxCap);
    localparam logic [WinW-1:0] WinMax = WinW'(WinCap);

    typedef enum logic [1:0] {
        IDLE,
        RUN,
        FIN
    } state_t;

    state_t state_reg, state_next;

    logic [LenW-1:0] length_a_reg, length_b_reg;
    logic [WinW-1:0] window_reg, allowance_reg;

    logic [PosW-1:0] pa_reg, pa_next, pb_reg, pb_next;
    logic [WinW-1:0] k_reg, k_next, win_reg, win_next;
    logic [CntW-1:0] matches_reg, matches_next;
    logic            rd_vld_reg, rd_vld_next;

    logic            res_dot_reg, res_dot_next;
    logic [CntW-1:0] res_cnt_reg, res_cnt_next;
    logic            res_oor_reg, res_oor_next;

    logic               m_valid_reg, m_valid_next;
    wdp_pkg::out_item_t m_data_reg, m_data_next;

    logic [LenW-1:0] la, lb;
    logic [WinW-1:0] win_eff;
    logic            accept;
    logic            wr_ok;
    logic            issue;
    logic            oor;
    logic [CntW:0]   score;
    logic            out_free;

    assign la      = (length_a_reg > LenMax) ? LenMax : length_a_reg;
    assign lb      = (length_b_reg > LenMax) ? LenMax : length_b_reg;
    assign win_eff = (window_reg > WinMax) ? WinMax : window_reg;

    assign s_ready  = (state_reg == IDLE);
    assign accept   = s_valid && s_ready;
    assign wr_ok    = {1'b0, s_data.load_index} < IdxLim;
    assign oor      = ({1'b0, s_data.col} >= la) || ({1'b0, s_data.row} >= lb);
    assign issue    = (state_reg == RUN) && (k_reg < win_reg)
                   && (pa_reg < la) && (pb_reg < lb);
    assign score    = {1'b0, matches_reg} + {1'b0, allowance_reg};
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        req_a.we    = accept && (s_data.func == wdp_pkg::FUNC_WR_A) && wr_ok;
        req_a.waddr = PosW'(s_data.load_index);
        req_a.wdata = s_data.symbol;
        req_a.re    = issue;
        req_a.raddr = pa_reg;
        req_b.we    = accept && (s_data.func == wdp_pkg::FUNC_WR_B) && wr_ok;
        req_b.waddr = PosW'(s_data.load_index);
        req_b.wdata = s_data.symbol;
        req_b.re    = issue;
        req_b.raddr = pb_reg;
    end

    always_comb begin
        state_next   = state_reg;
        pa_next      = pa_reg;
        pb_next      = pb_reg;
        k_next       = k_reg;
        win_next     = win_reg;
        matches_next = matches_reg;
        rd_vld_next  = 1'b0;
        res_dot_next = res_dot_reg;
        res_cnt_next = res_cnt_reg;
        res_oor_next = res_oor_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;

        case (state_reg)
            IDLE: begin
                if (accept && (s_data.func == wdp_pkg::FUNC_QUERY)) begin
                    if (oor) begin
                        res_dot_next = 1'b0;
                        res_cnt_next = '0;
                        res_oor_next = 1'b1;
                        state_next   = FIN;
                    end else begin
                        pa_next      = PosW'(s_data.col);
                        pb_next      = PosW'(s_data.row);
                        k_next       = '0;
                        win_next     = win_eff;
                        matches_next = '0;
                        state_next   = RUN;
                    end
                end
            end
            RUN: begin
                // address for pair k goes out while pair k-1 is compared
                if (issue) begin
                    pa_next = pa_reg + 1'b1;
                    pb_next = pb_reg + 1'b1;
                    k_next  = k_reg + 1'b1;
                end
                rd_vld_next = issue;
                if (rd_vld_reg && (rd_a == rd_b)) begin
                    matches_next = matches_reg + 1'b1;
                end
                if (!issue && !rd_vld_reg) begin
                    res_dot_next = score >= {1'b0, win_reg};
                    res_cnt_next = matches_reg;
                    res_oor_next = 1'b0;
                    state_next   = FIN;
                end
            end
            FIN: begin
                if (out_free) begin
                    m_valid_next             = 1'b1;
                    m_data_next.dot          = res_dot_reg;
                    m_data_next.match_count  = res_cnt_reg;
                    m_data_next.out_of_range = res_oor_reg;
                    state_next               = IDLE;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= IDLE;
            rd_vld_reg    <= 1'b0;
            m_valid_reg   <= 1'b0;
            length_a_reg  <= '0;
            length_b_reg  <= '0;
            window_reg    <= wdp_pkg::WINDOW_RST;
            allowance_reg <= wdp_pkg::ALLOWANCE_RST;
        end else begin
            state_reg   <= state_next;
            rd_vld_reg  <= rd_vld_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                case (cfg_index)
                    wdp_pkg::REG_LENGTH_A:  length_a_reg  <= cfg_wdata;
                    wdp_pkg::REG_LENGTH_B:  length_b_reg  <= cfg_wdata;
                    wdp_pkg::REG_WINDOW:    window_reg    <= cfg_wdata[WinW-1:0];
                    wdp_pkg::REG_ALLOWANCE: allowance_reg <= cfg_wdata[WinW-1:0];
                    default: ;
                endcase
            end
        end
        pa_reg      <= pa_next;
        pb_reg      <= pb_next;
        k_reg       <= k_next;
        win_reg     <= win_next;
        matches_reg <= matches_next;
        res_dot_reg <= res_dot_next;
        res_cnt_reg <= res_cnt_next;
        res_oor_reg <= res_oor_next;
        m_data_reg  <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_no_read_when_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !rd_vld_reg)
        else $error("read pending while accepting input");

    a_matches_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == RUN) |-> (matches_reg <= k_reg) && (k_reg <= win_reg))
        else $error("match count or pair index out of bounds");

    a_oor_result_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.out_of_range) |-> (!m_data.dot && (m_data.match_count == '0)))
        else $error("out-of-range result carries a dot or count");

    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !((req_a.we || req_b.we) && (req_a.re || req_b.re)))
        else $error("store written during a query");

    a_result_on_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == FIN) && out_free) |=> m_valid)
        else $error("finished result not presented");
`endif

endmodule
